// ===== design/odct1d_pkg.sv =====
`timescale 1ns / 1ps
// odct1d_pkg: shared constants, cosine table generator and scale function
// for the orthonormal dct core; no dependencies

package odct1d_pkg;

    localparam int MAX_LENGTH_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 19;
    localparam int POS_W    = 6;
    localparam int CFG_W    = 3;
    localparam int COS_W    = 18;
    localparam int SCALE_W  = 25;

    localparam logic [0:0] CFG_DIRECTION   = 1'd0;
    localparam logic [0:0] CFG_LENGTH_LOG2 = 1'd1;

    localparam logic       DIRECTION_RST   = 1'b0;
    localparam logic [2:0] LENGTH_LOG2_RST = 3'd6;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [24:0] RSQRT2_Q24  = 25'd11863283;
    localparam logic [24:0] ONE_Q24     = 25'h1000000;

    localparam logic [63:0] TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    // cosine of a q30 angle, 11-term taylor series, rounded to q1.17
    function automatic logic [COS_W-1:0] cos_q17(input logic [63:0] ang);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] usum;
        longint      sum;
        x2  = (ang * ang) >> 30;
        t   = 64'd1 << 30;
        sum = longint'(t);
        for (int i = 0; i < 10; i++) begin
            t = ((t * x2) >> 30) / TAYLOR_DIV[i];
            if (i % 2 == 0) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        usum = 64'(sum);
        return COS_W'((usum + 64'd4096) >> 13);
    endfunction

    // sqrt(2^-l) in q24
    function automatic logic [SCALE_W-1:0] scale_q24(input logic [2:0] l);
        logic [1:0]         s;
        logic [SCALE_W:0]   t;
        s = l[2:1];
        t = '0;
        if (!l[0]) begin
            return ONE_Q24 >> s;
        end
        if (s == 2'd0) begin
            return RSQRT2_Q24;
        end
        t = (SCALE_W + 1)'(RSQRT2_Q24) + ((SCALE_W + 1)'(1) << (s - 2'd1));
        return SCALE_W'(t >> s);
    endfunction

endpackage

// ===== design/odct1d_cos_rom.sv =====
`timescale 1ns / 1ps
// odct1d_cos_rom: quarter-wave cosine table in q1.17 with registered read
// depends on odct1d_pkg

module odct1d_cos_rom #(
    parameter int MAX_LENGTH = odct1d_pkg::MAX_LENGTH_DEF
) (
    input  logic                            i_clk,
    input  logic [$clog2(MAX_LENGTH):0]     i_idx,
    output logic [odct1d_pkg::COS_W-1:0]    o_cos
);

    logic [odct1d_pkg::COS_W-1:0] w_rom [0:MAX_LENGTH];

    for (genvar j = 0; j <= MAX_LENGTH; j++) begin : g_rom
        localparam logic [63:0] ANG =
            (64'(j) * odct1d_pkg::HALF_PI_Q30 + 64'(MAX_LENGTH / 2)) / 64'(MAX_LENGTH);
        assign w_rom[j] = odct1d_pkg::cos_q17(ANG);
    end

    always_ff @(posedge i_clk) begin
        o_cos <= w_rom[i_idx];
    end

endmodule

// ===== design/orthonormal_dct_1d_core.sv =====
`timescale 1ns / 1ps
// orthonormal_dct_1d_core: orthonormal dct-ii / dct-iii by direct sums on one
// shared multiplier; depends on odct1d_pkg and odct1d_cos_rom
// loading: one sample per cycle while busy is low, the n-th sample starts the transform
// compute: per result, an init step, n multiply-accumulate terms, a pipeline drain, then
// scale (low, high, element 0, add), absolute value and rounding; receiver cannot stall
// reset: synchronous active low; forward, length 64, count cleared, store not cleared

module orthonormal_dct_1d_core #(
    parameter int MAX_LENGTH = odct1d_pkg::MAX_LENGTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [odct1d_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                    i_cfg_wr_en,
    input  logic [0:0]                              i_cfg_idx,
    input  logic [odct1d_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                    o_valid,
    output logic signed [odct1d_pkg::VALUE_W-1:0]   o_value,
    output logic [odct1d_pkg::POS_W-1:0]            o_position,
    output logic                                    o_final_res
);

    localparam int MLOG   = $clog2(MAX_LENGTH);
    localparam int CNT_W  = MLOG + 1;
    localparam int IDX_W  = MLOG + 1;
    localparam int PH_W   = MLOG + 2;
    localparam int SH_W   = $clog2(MLOG + 1);
    localparam int ACC_W  = MLOG + 34;
    localparam int LO_W   = 22;
    localparam int FIN_W  = MLOG + 59;
    localparam int RND_W  = FIN_W - 40;
    localparam int MA_W   = 23;
    localparam int MB_W   = 26;
    localparam int MP_W   = MA_W + MB_W;
    localparam int SW     = odct1d_pkg::SAMPLE_W;
    localparam int VW     = odct1d_pkg::VALUE_W;
    localparam int CW     = odct1d_pkg::COS_W;
    localparam int SCW    = odct1d_pkg::SCALE_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_INIT   = 10'b00_0000_0010,
        S_MAC    = 10'b00_0000_0100,
        S_DRAIN  = 10'b00_0000_1000,
        S_SC_LO  = 10'b00_0001_0000,
        S_SC_HI  = 10'b00_0010_0000,
        S_SC_E0  = 10'b00_0100_0000,
        S_SC_ADD = 10'b00_1000_0000,
        S_ABS    = 10'b01_0000_0000,
        S_RND    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic                   r_dir;
    logic [2:0]             r_len;
    logic [CNT_W-1:0]       r_load_cnt;
    logic [SW-1:0]          r_store [0:MAX_LENGTH-1];

    logic [MLOG-1:0]        r_o;
    logic [MLOG-1:0]        r_cnt;
    logic [PH_W-1:0]        r_phase;
    logic [PH_W-1:0]        r_delta;

    logic                   r_v1, r_first1, r_neg;
    logic                   r_v2;
    logic signed [SW-1:0]   r_elem;
    logic signed [SW-1:0]   r_elem0;
    logic signed [MP_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [FIN_W-1:0] r_fin;
    logic [FIN_W-1:0]       r_mag;
    logic                   r_sgn;

    logic                   r_valid;
    logic signed [VW-1:0]   r_value;
    logic [odct1d_pkg::POS_W-1:0] r_position;
    logic                   r_final;

    logic [2:0]             w_l;
    logic [CNT_W-1:0]       w_n;
    logic [MLOG-1:0]        w_nm1;
    logic [SH_W-1:0]        w_sh;
    logic [SCW-1:0]         w_a0, w_ak, w_scale;
    logic [CNT_W-1:0]       w_cnt_inc;
    logic                   w_accept, w_done, w_last;
    logic [1:0]             w_q;
    logic [MLOG-1:0]        w_r;
    logic [IDX_W-1:0]       w_idx;
    logic [CW-1:0]          w_cos;
    logic signed [CW:0]     w_cos_s;
    logic signed [MA_W-1:0] w_mul_a;
    logic signed [MB_W-1:0] w_mul_b;
    logic [PH_W-1:0]        w_o_ph;
    logic signed [FIN_W-1:0] w_prod_ext;
    logic [RND_W-1:0]       w_rnd;
    logic signed [VW-1:0]   w_sat;
    logic [MLOG+5:0]        w_o_ext;

    // transform length and scales
    assign w_l       = (32'(r_len) > MLOG) ? 3'(MLOG) : r_len;
    assign w_n       = CNT_W'(1) << w_l;
    assign w_nm1     = MLOG'(w_n - CNT_W'(1));
    assign w_sh      = SH_W'(MLOG) - SH_W'(w_l);
    assign w_a0      = odct1d_pkg::scale_q24(w_l);
    assign w_ak      = (w_l != 3'd0) ? odct1d_pkg::scale_q24(w_l - 3'd1) : w_a0;
    assign w_scale   = (!r_dir && r_o == '0) ? w_a0 : w_ak;

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_cnt_inc = r_load_cnt + CNT_W'(1);
    assign w_done    = (w_cnt_inc >= w_n);
    assign w_last    = (r_o == w_nm1);

    // phase to quarter-wave table index
    assign w_q   = r_phase[PH_W-1 -: 2];
    assign w_r   = r_phase[MLOG-1:0];
    assign w_idx = w_q[0] ? (IDX_W'(MAX_LENGTH) - IDX_W'(w_r)) : IDX_W'(w_r);
    assign w_o_ph = PH_W'(r_o);

    odct1d_cos_rom #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_cos_rom (
        .i_clk (i_clk),
        .i_idx (w_idx),
        .o_cos (w_cos)
    );

    assign w_cos_s = r_neg ? -$signed({1'b0, w_cos}) : $signed({1'b0, w_cos});

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_SC_LO: begin
                w_mul_a = $signed({1'b0, r_acc[LO_W-1:0]});
                w_mul_b = $signed({1'b0, w_scale});
            end
            S_SC_HI: begin
                w_mul_a = MA_W'($signed(r_acc[ACC_W-1:LO_W]));
                w_mul_b = $signed({1'b0, w_scale});
            end
            S_SC_E0: begin
                w_mul_a = r_dir ? MA_W'(r_elem0) : '0;
                w_mul_b = $signed({1'b0, w_a0});
            end
            default: begin
                w_mul_a = MA_W'(r_elem);
                w_mul_b = MB_W'(w_cos_s);
            end
        endcase
    end

    assign w_prod_ext = FIN_W'(r_prod);

    // round half away from zero, saturate
    assign w_rnd = RND_W'(r_mag[FIN_W-1:41]) + RND_W'(r_mag[40]);
    always_comb begin
        if (r_sgn) begin
            w_sat = (w_rnd > RND_W'(262144)) ? VW'(-262144) : -$signed(VW'(w_rnd));
        end else begin
            w_sat = (w_rnd > RND_W'(262143)) ? VW'(262143) : $signed(VW'(w_rnd));
        end
    end

    assign w_o_ext = (MLOG + 6)'(r_o);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept && w_done) n_state = S_INIT;
            S_INIT:   n_state = S_MAC;
            S_MAC:    if (r_cnt == w_nm1) n_state = S_DRAIN;
            S_DRAIN:  if (!r_v1 && !r_v2) n_state = S_SC_LO;
            S_SC_LO:  n_state = S_SC_HI;
            S_SC_HI:  n_state = S_SC_E0;
            S_SC_E0:  n_state = S_SC_ADD;
            S_SC_ADD: n_state = S_ABS;
            S_ABS:    n_state = S_RND;
            S_RND:    n_state = w_last ? S_IDLE : S_INIT;
            default:  n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dir      <= odct1d_pkg::DIRECTION_RST;
            r_len      <= odct1d_pkg::LENGTH_LOG2_RST;
            r_load_cnt <= '0;
            r_o        <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    odct1d_pkg::CFG_DIRECTION:   r_dir <= i_cfg_data[0];
                    odct1d_pkg::CFG_LENGTH_LOG2: r_len <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_load_cnt <= w_done ? '0 : w_cnt_inc;
                r_o        <= '0;
            end
            if (r_state == S_RND && !w_last) begin
                r_o <= r_o + MLOG'(1);
            end
            r_v1    <= (r_state == S_MAC);
            r_v2    <= r_v1 && !(r_dir && r_first1);
            r_valid <= (r_state == S_RND);
        end
    end

    // sample store
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[r_load_cnt[MLOG-1:0]] <= i_sample;
        end
        r_elem <= $signed(r_store[r_cnt]);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod   <= w_mul_a * w_mul_b;
        r_first1 <= (r_cnt == '0);
        r_neg    <= w_q[1] ^ w_q[0];
        if (r_v1 && r_first1) begin
            r_elem0 <= r_elem;
        end
        if (r_v2) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
        case (r_state)
            S_INIT: begin
                r_cnt <= '0;
                r_acc <= '0;
                if (r_dir) begin
                    r_phase <= '0;
                    r_delta <= PH_W'({r_o, 1'b1}) << w_sh;
                end else begin
                    r_phase <= w_o_ph << w_sh;
                    r_delta <= w_o_ph << (w_sh + SH_W'(1));
                end
            end
            S_MAC: begin
                r_cnt   <= r_cnt + MLOG'(1);
                r_phase <= r_phase + r_delta;
            end
            S_SC_HI:  r_fin <= w_prod_ext;
            S_SC_E0:  r_fin <= r_fin + (w_prod_ext <<< LO_W);
            S_SC_ADD: r_fin <= r_fin + (w_prod_ext <<< 17);
            S_ABS: begin
                r_sgn <= r_fin[FIN_W-1];
                r_mag <= r_fin[FIN_W-1] ? FIN_W'(-r_fin) : FIN_W'(r_fin);
            end
            S_RND: begin
                r_value    <= w_sat;
                r_position <= w_o_ext[5:0];
                r_final    <= w_last;
            end
            default: ;
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_position  = r_position;
    assign o_final_res = r_final;

    // results are spaced by the scale and rounding steps
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes in consecutive cycles");

    // last element of a vector returns the block to idle
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_res) |-> !busy)
        else $error("busy after final result");

    // a sample that does not complete the vector only advances the count
    a_load_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !w_done) |=>
            (!busy && r_load_cnt == $past(w_cnt_inc)))
        else $error("load count did not advance");

endmodule
